### hdl/ase_pkg.sv
// shared types for the ascending sort engine
package ase_pkg;

    // word width of one sorted item
    localparam int unsigned WORD_W = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic insert;     // place the incoming word into the cell chain
        logic set_drop;   // remember that a word was dropped
        logic shift;      // move the chain down by one after an output transaction
        logic clr_drop;   // clear the drop flag when the set is done
    } ase_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;       // every cell holds a word
        logic one_left;   // exactly one word remains to be emitted
    } ase_sts_t;

    // controller states
    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } ase_state_t;

endpackage

### hdl/ase_datapath.sv
// insertion cell chain, word count and drop flag
module ase_datapath #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ase_pkg::ase_cmd_t                    cmd,
    input  logic signed [ase_pkg::WORD_W-1:0]    in_word,
    output ase_pkg::ase_sts_t                    sts,
    output logic signed [ase_pkg::WORD_W-1:0]    head_word,
    output logic                                 dropped
);
    import ase_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic signed [WORD_W-1:0] cell_reg  [CAPACITY];
    logic signed [WORD_W-1:0] cell_next [CAPACITY];
    logic        [CAPACITY-1:0] gt;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;

    // per-cell compare: an empty cell acts as plus infinity
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = (CNT_W'(i) >= count_reg) || (cell_reg[i] > in_word);
        end
    end

    // next value of each cell: insert opens a slot, shift moves down
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] from_left;
        logic                     left_gt;
        logic signed [WORD_W-1:0] from_right;

        if (i == 0)
        begin : g_first
            assign from_left = in_word;
            assign left_gt   = 1'b0;
        end
        else
        begin : g_mid
            assign from_left = cell_reg[i-1];
            assign left_gt   = gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign from_right = cell_reg[i];
        end
        else
        begin : g_inner
            assign from_right = cell_reg[i+1];
        end

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.insert && gt[i])
            begin
                cell_next[i] = left_gt ? from_left : in_word;
            end
            else if (cmd.shift)
            begin
                cell_next[i] = from_right;
            end
        end
    end

    // cell storage, payload only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // fill count and drop flag
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.set_drop)
        begin
            dropped_next = 1'b1;
        end
        else if (cmd.clr_drop)
        begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // status and outputs
    assign sts.full     = (count_reg == CNT_W'(CAPACITY));
    assign sts.one_left = (count_reg == CNT_W'(1));
    assign head_word    = cell_reg[0];
    assign dropped      = dropped_reg;

    // count never passes the number of cells
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("word count above capacity");

    // no insert into a full chain
    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !sts.full)
        else $error("insert while chain full");

    // no shift out of an empty chain
    a_no_shift_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> (count_reg != '0))
        else $error("shift while chain empty");

    // last shift of a set leaves the chain empty and the flag clear
    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && sts.one_left) |=> (count_reg == '0) && !dropped_reg)
        else $error("set not cleared after final word");

endmodule

### hdl/ase_ctrl.sv
// load and emit state machine
module ase_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  ase_pkg::ase_sts_t  sts,
    output ase_pkg::ase_cmd_t  cmd
);
    import ase_pkg::*;

    ase_state_t state_reg, state_next;
    logic       in_xfer;
    logic       out_xfer;

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // commands and next state
    always_comb
    begin
        state_next   = state_reg;
        cmd.insert   = 1'b0;
        cmd.set_drop = 1'b0;
        cmd.shift    = 1'b0;
        cmd.clr_drop = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    cmd.insert   = !sts.full;
                    cmd.set_drop = sts.full;
                    if (s_tlast)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    cmd.shift = 1'b1;
                    if (sts.one_left)
                    begin
                        cmd.clr_drop = 1'b1;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // input and output sides are never open together
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("both channels open");

    // a closing input transaction starts the emit phase
    a_close_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tlast) |=> m_tvalid)
        else $error("closing word did not start emit");

    // the final output transaction of a set reopens the input side
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && sts.one_left) |=> s_tready)
        else $error("emit did not end after final word");

endmodule

### hdl/ascending_sort_engine_top.sv
// top level of the ascending sort engine
//
// Sorts a set of signed 32-bit words into ascending order.
// Input channel s_*: one word per transaction in s_tdata, s_tlast marks
// the word that closes the set. Words are taken one per cycle; each is
// placed at once into a chain of CAPACITY insertion cells, each cell with
// its own compare, so the chain is always sorted.
// Output channel m_*: after the closing transaction the engine emits
// every stored word smallest first, one per cycle while m_tready is high;
// the first result is valid the cycle after the closing transaction.
// m_tlast marks the greatest word, m_tuser flags a set that lost words
// because more than CAPACITY arrived (extra words are discarded).
// The input side is held off (s_tready low) while a set is being emitted.
// A stall on m_tready simply holds the current result; nothing is lost.
// Reset clears the word count, the drop flag and the state machine; the
// cell contents need no reset.
module ascending_sort_engine_top #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tuser,   // [0] overflow
    output logic        m_tlast
);
    import ase_pkg::*;

    ase_cmd_t                 cmd;
    ase_sts_t                 sts;
    logic signed [WORD_W-1:0] head_word;
    logic                     dropped;

    // sequencing
    ase_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // insertion chain
    ase_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   ($signed(s_tdata)),
        .sts       (sts),
        .head_word (head_word),
        .dropped   (dropped)
    );

    // result fields
    assign m_tdata = head_word;
    assign m_tuser = dropped;
    assign m_tlast = sts.one_left;

endmodule
